// ===== design/sfcs_pkg.sv =====
// Shared types, constants and codes of the SPI flash command sequencer.
`default_nettype none
package sfcs_pkg;

  // Default geometry and bounds; page and erase block sizes are powers of two.
  localparam int PAGE_BYTES_DEFAULT        = 256;
  localparam int ERASE_BLOCK_BYTES_DEFAULT = 65536;
  localparam int MAX_PROGRAM_BYTES_DEFAULT = 8192;
  localparam int MAX_ERASE_BYTES_DEFAULT   = 2097152;

  localparam int MAX_FRAMES  = 33;
  localparam int FRAME_CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int QUEUE_DEPTH = 2;

  // Request operations.
  localparam logic [2:0] OP_READ        = 3'd0;
  localparam logic [2:0] OP_PROGRAM     = 3'd1;
  localparam logic [2:0] OP_ERASE_4K    = 3'd2;
  localparam logic [2:0] OP_ERASE_64K   = 3'd3;
  localparam logic [2:0] OP_ERASE_RANGE = 3'd4;
  localparam logic [2:0] OP_UNPROTECT   = 3'd5;

  // Configuration register indexes.
  localparam logic CFG_MANUFACTURER_ID = 1'b0;
  localparam logic CFG_MEMORY_TYPE_ID  = 1'b1;

  // SPI opcodes.
  localparam logic [7:0] SPI_NOP       = 8'h00;
  localparam logic [7:0] SPI_READ      = 8'h03;
  localparam logic [7:0] SPI_PAGE_PROG = 8'h02;
  localparam logic [7:0] SPI_ERASE_4K  = 8'h20;
  localparam logic [7:0] SPI_ERASE_64K = 8'hD8;
  localparam logic [7:0] SPI_ULBPR     = 8'h98;
  localparam logic [7:0] SPI_EWSR      = 8'h50;
  localparam logic [7:0] SPI_WRSR      = 8'h01;

  // JEDEC id bytes that select the unprotect sequence.
  localparam logic [7:0] JEDEC_MFR_A      = 8'hBF;
  localparam logic [7:0] JEDEC_TYPE_ULBPR = 8'h26;
  localparam logic [7:0] JEDEC_TYPE_WRSR  = 8'h25;
  localparam logic [7:0] JEDEC_MFR_B      = 8'h62;

  // Job kinds handed from the front to the back.
  localparam logic [2:0] KIND_NOP     = 3'd0;
  localparam logic [2:0] KIND_ERROR   = 3'd1;
  localparam logic [2:0] KIND_READ    = 3'd2;
  localparam logic [2:0] KIND_PROGRAM = 3'd3;
  localparam logic [2:0] KIND_ERASE   = 3'd4;
  localparam logic [2:0] KIND_ULBPR   = 3'd5;
  localparam logic [2:0] KIND_WRSR    = 3'd6;

  typedef struct packed {
    logic [2:0]  operation;
    logic [23:0] start_address;
    logic [21:0] byte_length;
  } request_t;

  typedef struct packed {
    logic [7:0]  command_opcode;
    logic [23:0] frame_address;
    logic        has_address;
    logic [12:0] buffer_offset;
    logic [15:0] data_count;
    logic        receives_data;
    logic        write_enable_first;
    logic        poll_ready_after;
    logic        no_operation;
    logic        length_error;
    logic        last_frame;
  } frame_t;

  typedef struct packed {
    logic [2:0]             kind;
    logic [7:0]             opcode;
    logic [23:0]            address;
    logic [15:0]            length;
    logic [FRAME_CNT_W-1:0] frames;
  } job_t;

endpackage
`default_nettype wire

// ===== design/spi_flash_command_sequencer_unit.sv =====
// Top level of the SPI flash command sequencer.
//
// A request beat (operation, start address, byte length) on the request channel
// becomes one or more frame beats on the frame channel, in order; last_frame marks
// the final beat of each request. The user must write the JEDEC id registers
// (cfg_write / cfg_index / cfg_data) only while the block is idle; it does not check.
//
// The front end classifies each request in the cycle it is accepted and places a
// job in a two-entry queue, so requests are taken while earlier ones are still
// being sequenced. The back end loads one job at a time and then emits its frames in
// order into the output register, taking the next job only after the last frame;
// that frame loop sets the sustained rate.
//
// Frames wait in an output register while frame_ready is low; the back end holds
// its job and the queue fills, after which request_ready drops. A synchronous
// reset empties the queue, drops frame_valid and clears both id registers to 0.
`default_nettype none
module spi_flash_command_sequencer_unit #(
  parameter int PAGE_BYTES        = sfcs_pkg::PAGE_BYTES_DEFAULT,
  parameter int ERASE_BLOCK_BYTES = sfcs_pkg::ERASE_BLOCK_BYTES_DEFAULT,
  parameter int MAX_PROGRAM_BYTES = sfcs_pkg::MAX_PROGRAM_BYTES_DEFAULT,
  parameter int MAX_ERASE_BYTES   = sfcs_pkg::MAX_ERASE_BYTES_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic               cfg_index,
  input  wire logic [7:0]         cfg_data,
  input  wire logic               request_valid,
  output logic                    request_ready,
  input  wire sfcs_pkg::request_t request,
  output logic                    frame_valid,
  input  wire logic               frame_ready,
  output sfcs_pkg::frame_t        frame
);

  localparam int JOB_W = $bits(sfcs_pkg::job_t);

  sfcs_pkg::job_t new_job;
  sfcs_pkg::job_t head_job;
  logic [JOB_W-1:0] head_bits;
  logic             head_valid;
  logic             head_ready;

  sfcs_front #(
    .PAGE_BYTES        (PAGE_BYTES),
    .ERASE_BLOCK_BYTES (ERASE_BLOCK_BYTES),
    .MAX_PROGRAM_BYTES (MAX_PROGRAM_BYTES),
    .MAX_ERASE_BYTES   (MAX_ERASE_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (request),
    .job       (new_job)
  );

  sfcs_queue #(
    .WIDTH (JOB_W),
    .DEPTH (sfcs_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (request_valid),
    .push_ready (request_ready),
    .push_data  (new_job),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_data   (head_bits)
  );

  assign head_job = head_bits;

  sfcs_back #(
    .PAGE_BYTES        (PAGE_BYTES),
    .ERASE_BLOCK_BYTES (ERASE_BLOCK_BYTES),
    .MAX_PROGRAM_BYTES (MAX_PROGRAM_BYTES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (head_valid),
    .job_ready   (head_ready),
    .job_in      (head_job),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

endmodule
`default_nettype wire

// ===== design/sfcs_queue.sv =====
// Small first-in first-out queue of jobs between the front and the back.
`default_nettype none
module sfcs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/sfcs_front.sv =====
// Request front end: holds the JEDEC id registers and turns a request into a job.
`default_nettype none
module sfcs_front #(
  parameter int PAGE_BYTES        = sfcs_pkg::PAGE_BYTES_DEFAULT,
  parameter int ERASE_BLOCK_BYTES = sfcs_pkg::ERASE_BLOCK_BYTES_DEFAULT,
  parameter int MAX_PROGRAM_BYTES = sfcs_pkg::MAX_PROGRAM_BYTES_DEFAULT,
  parameter int MAX_ERASE_BYTES   = sfcs_pkg::MAX_ERASE_BYTES_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic               cfg_index,
  input  wire logic [7:0]         cfg_data,
  input  wire sfcs_pkg::request_t req,
  output sfcs_pkg::job_t          job
);

  localparam int PL = $clog2(PAGE_BYTES);
  localparam int BL = $clog2(ERASE_BLOCK_BYTES);

  logic [7:0]  vendor_id;
  logic [7:0]  memory_type_id;
  logic [23:0] prog_span;
  logic [23:0] prog_frames;
  logic [23:0] erase_span;
  logic [23:0] erase_frames;
  logic [23:0] block_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      vendor_id      <= '0;
      memory_type_id <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sfcs_pkg::CFG_MANUFACTURER_ID: vendor_id      <= cfg_data;
        sfcs_pkg::CFG_MEMORY_TYPE_ID:  memory_type_id <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame counts: the offset into the first page or block plus the length,
  // rounded up to whole pages or blocks.
  assign prog_span    = 24'(req.start_address[PL-1:0]) + 24'(req.byte_length)
                        + 24'(PAGE_BYTES - 1);
  assign prog_frames  = prog_span >> PL;
  assign erase_span   = 24'(req.start_address[BL-1:0]) + 24'(req.byte_length)
                        + 24'(ERASE_BLOCK_BYTES - 1);
  assign erase_frames = erase_span >> BL;
  assign block_base   = req.start_address & ~24'(ERASE_BLOCK_BYTES - 1);

  always_comb begin
    job.kind    = sfcs_pkg::KIND_NOP;
    job.opcode  = sfcs_pkg::SPI_NOP;
    job.address = req.start_address;
    job.length  = req.byte_length[15:0];
    job.frames  = sfcs_pkg::FRAME_CNT_W'(1);
    unique case (req.operation)
      sfcs_pkg::OP_READ: begin
        if (req.byte_length == '0) begin
          job.kind = sfcs_pkg::KIND_NOP;
        end else if (req.byte_length > 22'hFFFF) begin
          job.kind = sfcs_pkg::KIND_ERROR;
        end else begin
          job.kind = sfcs_pkg::KIND_READ;
        end
      end
      sfcs_pkg::OP_PROGRAM: begin
        if (req.byte_length > 22'(MAX_PROGRAM_BYTES)) begin
          job.kind = sfcs_pkg::KIND_ERROR;
        end else if (req.byte_length == '0) begin
          job.kind = sfcs_pkg::KIND_NOP;
        end else if (prog_frames > 24'(sfcs_pkg::MAX_FRAMES)) begin
          job.kind = sfcs_pkg::KIND_ERROR;
        end else begin
          job.kind = sfcs_pkg::KIND_PROGRAM;
        end
      end
      sfcs_pkg::OP_ERASE_4K: begin
        job.kind   = sfcs_pkg::KIND_ERASE;
        job.opcode = sfcs_pkg::SPI_ERASE_4K;
      end
      sfcs_pkg::OP_ERASE_64K: begin
        job.kind   = sfcs_pkg::KIND_ERASE;
        job.opcode = sfcs_pkg::SPI_ERASE_64K;
      end
      sfcs_pkg::OP_ERASE_RANGE: begin
        job.opcode  = sfcs_pkg::SPI_ERASE_64K;
        job.address = block_base;
        job.frames  = erase_frames[sfcs_pkg::FRAME_CNT_W-1:0];
        if (req.byte_length > 22'(MAX_ERASE_BYTES)) begin
          job.kind = sfcs_pkg::KIND_ERROR;
        end else if (req.byte_length == '0) begin
          job.kind = sfcs_pkg::KIND_NOP;
        end else if (erase_frames > 24'(sfcs_pkg::MAX_FRAMES)) begin
          job.kind = sfcs_pkg::KIND_ERROR;
        end else begin
          job.kind = sfcs_pkg::KIND_ERASE;
        end
      end
      sfcs_pkg::OP_UNPROTECT: begin
        if (vendor_id == sfcs_pkg::JEDEC_MFR_A
            && memory_type_id == sfcs_pkg::JEDEC_TYPE_ULBPR) begin
          job.kind = sfcs_pkg::KIND_ULBPR;
        end else if ((vendor_id == sfcs_pkg::JEDEC_MFR_A
                      && memory_type_id == sfcs_pkg::JEDEC_TYPE_WRSR)
                     || vendor_id == sfcs_pkg::JEDEC_MFR_B) begin
          job.kind   = sfcs_pkg::KIND_WRSR;
          job.frames = sfcs_pkg::FRAME_CNT_W'(2);
        end else begin
          job.kind = sfcs_pkg::KIND_NOP;
        end
      end
      default: job.kind = sfcs_pkg::KIND_NOP;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/sfcs_back.sv =====
// Frame sequencer: walks one job at a time and emits its frames into an output register.
`default_nettype none
module sfcs_back #(
  parameter int PAGE_BYTES        = sfcs_pkg::PAGE_BYTES_DEFAULT,
  parameter int ERASE_BLOCK_BYTES = sfcs_pkg::ERASE_BLOCK_BYTES_DEFAULT,
  parameter int MAX_PROGRAM_BYTES = sfcs_pkg::MAX_PROGRAM_BYTES_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           job_valid,
  output logic                job_ready,
  input  wire sfcs_pkg::job_t job_in,
  output logic                frame_valid,
  input  wire logic           frame_ready,
  output sfcs_pkg::frame_t    frame
);

  localparam int PL = $clog2(PAGE_BYTES);
  localparam int PW = PL + 1;
  localparam int RW = $clog2(MAX_PROGRAM_BYTES + 1);
  localparam int CW = (RW > PW) ? RW : PW;

  logic                            busy;
  logic [2:0]                      kind;
  logic [7:0]                      opcode;
  logic [23:0]                     addr;
  logic [15:0]                     length;
  logic [RW-1:0]                   remaining;
  logic [RW-1:0]                   done;
  logic [sfcs_pkg::FRAME_CNT_W-1:0] frames_left;

  logic [PW-1:0]    page_room;
  logic [CW-1:0]    chunk;
  logic             emit;
  logic             final_frame;
  sfcs_pkg::frame_t next_frame;

  assign job_ready = !busy;
  assign emit      = busy && (!frame_valid || frame_ready);

  // Bytes left before the next page boundary, capped by what is left to program.
  assign page_room = PW'(PAGE_BYTES) - PW'(addr[PL-1:0]);
  assign chunk     = (CW'(remaining) < CW'(page_room)) ? CW'(remaining) : CW'(page_room);

  always_comb begin
    next_frame  = '0;
    final_frame = 1'b1;
    unique case (kind)
      sfcs_pkg::KIND_READ: begin
        next_frame.command_opcode = sfcs_pkg::SPI_READ;
        next_frame.frame_address  = addr;
        next_frame.has_address    = 1'b1;
        next_frame.data_count     = length;
        next_frame.receives_data  = 1'b1;
      end
      sfcs_pkg::KIND_PROGRAM: begin
        final_frame                   = (CW'(remaining) == chunk);
        next_frame.command_opcode     = sfcs_pkg::SPI_PAGE_PROG;
        next_frame.frame_address      = addr;
        next_frame.has_address        = 1'b1;
        next_frame.buffer_offset      = 13'(done);
        next_frame.data_count         = 16'(chunk);
        next_frame.write_enable_first = 1'b1;
        next_frame.poll_ready_after   = 1'b1;
      end
      sfcs_pkg::KIND_ERASE: begin
        final_frame                   = (frames_left == sfcs_pkg::FRAME_CNT_W'(1));
        next_frame.command_opcode     = opcode;
        next_frame.frame_address      = addr;
        next_frame.has_address        = 1'b1;
        next_frame.write_enable_first = 1'b1;
        next_frame.poll_ready_after   = 1'b1;
      end
      sfcs_pkg::KIND_ULBPR: begin
        next_frame.command_opcode     = sfcs_pkg::SPI_ULBPR;
        next_frame.write_enable_first = 1'b1;
        next_frame.poll_ready_after   = 1'b1;
      end
      sfcs_pkg::KIND_WRSR: begin
        // Enable status write first, then write one byte to the status register.
        final_frame = (frames_left == sfcs_pkg::FRAME_CNT_W'(1));
        if (final_frame) begin
          next_frame.command_opcode   = sfcs_pkg::SPI_WRSR;
          next_frame.data_count       = 16'd1;
          next_frame.poll_ready_after = 1'b1;
        end else begin
          next_frame.command_opcode = sfcs_pkg::SPI_EWSR;
        end
      end
      sfcs_pkg::KIND_ERROR: begin
        next_frame.no_operation = 1'b1;
        next_frame.length_error = 1'b1;
      end
      default: next_frame.no_operation = 1'b1;
    endcase
    next_frame.last_frame = final_frame;
  end

  always_ff @(posedge clk) begin
    if (!busy && job_valid) begin
      kind        <= job_in.kind;
      opcode      <= job_in.opcode;
      addr        <= job_in.address;
      length      <= job_in.length;
      remaining   <= job_in.length[RW-1:0];
      done        <= '0;
      frames_left <= job_in.frames;
    end else if (emit) begin
      if (kind == sfcs_pkg::KIND_PROGRAM) begin
        addr      <= addr + 24'(chunk);
        remaining <= remaining - RW'(chunk);
        done      <= done + RW'(chunk);
      end else begin
        addr <= addr + 24'(ERASE_BLOCK_BYTES);
      end
      frames_left <= frames_left - 1'b1;
    end
    if (emit) begin
      frame <= next_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      frame_valid <= 1'b0;
    end else begin
      if (!busy && job_valid) begin
        busy <= 1'b1;
      end else if (emit && final_frame) begin
        busy <= 1'b0;
      end
      if (emit) begin
        frame_valid <= 1'b1;
      end else if (frame_ready) begin
        frame_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/sfcs_checker.sv =====
// Port-level checks of the sequencer's frame channel, bound to the top level.
`default_nettype none
module sfcs_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             frame_valid,
  input wire logic             frame_ready,
  input wire sfcs_pkg::frame_t frame
);

  // A stalled beat keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    frame_valid && !frame_ready |=> frame_valid && $stable(frame))
    else $error("frame beat changed while stalled");

  assert property (@(posedge clk)
    rst |=> !frame_valid)
    else $error("frame valid after reset");

  // A no-op beat closes its request and carries no opcode.
  assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame.no_operation |->
      frame.last_frame && frame.command_opcode == sfcs_pkg::SPI_NOP)
    else $error("no-op beat not final or has an opcode");

  assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame.length_error |-> frame.no_operation && frame.data_count == '0)
    else $error("length error on a live frame");

  assert property (@(posedge clk) disable iff (rst)
    frame_valid && !frame.has_address |-> frame.frame_address == '0)
    else $error("address on a frame without address bytes");

endmodule

bind spi_flash_command_sequencer_unit sfcs_checker u_sfcs_checker (
  .clk         (clk),
  .rst         (rst),
  .frame_valid (frame_valid),
  .frame_ready (frame_ready),
  .frame       (frame)
);
`default_nettype wire
